// ===== rtl/shs_pkg.sv =====
// shared types, constants and round functions for the sha-256 stream hasher
package shs_pkg;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MARK  = 7'b0000010,
        ST_ZERO  = 7'b0000100,
        ST_LEN   = 7'b0001000,
        ST_ROUND = 7'b0010000,
        ST_FOLD  = 7'b0100000,
        ST_HAND  = 7'b1000000
    } state_t;

    // eight hash words, element 0 is the most significant digest word
    typedef logic [7:0][31:0] hash_t;

    // commands to the compression core
    typedef struct packed {
        logic load;    // copy hash words into working variables
        logic step;    // run one round
        logic fold;    // add working variables into hash words
        logic reinit;  // restore initial hash values
    } core_ctrl_t;

    // commands to the message schedule
    typedef struct packed {
        logic        push;  // shift in a freshly packed message word
        logic        step;  // shift in the next expanded schedule word
        logic [31:0] word;
    } sched_cmd_t;

    localparam logic [7:0] PAD_MARK        = 8'h80;
    localparam logic [5:0] BLOCK_LAST_BYTE = 6'd63;
    localparam logic [5:0] LEN_START_BYTE  = 6'd56;
    localparam logic [5:0] ROUND_LAST      = 6'd63;
    localparam logic [2:0] LEN_LAST_BYTE   = 3'd7;
    localparam logic [2:0] DIGEST_LAST     = 3'd7;
    localparam logic [1:0] WORD_LAST_LANE  = 2'd3;

    // initial hash values, element 0 in the lowest bits
    localparam hash_t HASH_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    // round constants
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/shs_sched.sv =====
// message schedule: sixteen-word shift line that holds the block and expands it
module shs_sched (
    input  logic               aclk,
    input  shs_pkg::sched_cmd_t cmd,
    output logic [31:0]        w_t
);
    import shs_pkg::*;

    logic [31:0] w_reg [16];
    logic [31:0] expand;
    logic [31:0] shift_in;

    // next expanded word from the current window
    assign expand = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    assign shift_in = cmd.step ? expand : cmd.word;

    // oldest word sits at tap zero and feeds the round
    always_ff @(posedge aclk) begin
        if (cmd.push || cmd.step) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= shift_in;
        end
    end

    assign w_t = w_reg[0];

endmodule

// ===== rtl/shs_core.sv =====
// compression core: hash words, working variables and the shared round unit
module shs_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  shs_pkg::core_ctrl_t ctrl,
    input  logic [5:0]         round_idx,
    input  logic [31:0]        w_t,
    output shs_pkg::hash_t     hash
);
    import shs_pkg::*;

    hash_t       hash_reg;
    hash_t       v_reg;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] choose;
    logic [31:0] major;

    // one round of the compression function
    assign choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1 = v_reg[7] + big_sigma1(v_reg[4]) + choose + round_k(round_idx) + w_t;
    assign t2 = big_sigma0(v_reg[0]) + major;

    // working variables
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            v_reg <= hash_reg;
        end else if (ctrl.step) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // running hash
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= HASH_INIT;
        end else if (ctrl.reinit) begin
            hash_reg <= HASH_INIT;
        end else if (ctrl.fold) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= hash_reg[i] + v_reg[i];
            end
        end
    end

    assign hash = hash_reg;

endmodule

// ===== rtl/shs_outbuf.sv =====
// digest buffer that streams eight words while the hasher goes on
module shs_outbuf (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  shs_pkg::hash_t digest,
    output logic           busy,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [39:0]    m_tdata,   // digest_word[31:0], word_number[34:32], zero fill
    output logic           m_tlast    // last_word
);
    import shs_pkg::*;

    hash_t      words_reg;
    logic [2:0] cnt_reg;
    logic       busy_reg;
    logic       xfer;

    assign xfer = busy_reg && m_tready;

    // control: word counter and valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (xfer) begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == DIGEST_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // payload: head word at element zero, shifts down on each transfer
    always_ff @(posedge aclk) begin
        if (load) begin
            words_reg <= digest;
        end else if (xfer) begin
            words_reg <= words_reg >> 32;
        end
    end

    assign busy     = busy_reg;
    assign m_tvalid = busy_reg;
    assign m_tdata  = {5'b0, cnt_reg, words_reg[0]};
    assign m_tlast  = (cnt_reg == DIGEST_LAST);

endmodule

// ===== rtl/sha256_stream_hasher_top.sv =====
// top level of the sha-256 stream hasher: byte packing, padding sequencer and core
//
// Input channel s_*: one transfer per message item. s_tdata[7:0] is the message
// byte, s_tuser says that the byte is present, s_tlast ends the message after
// this transfer's byte (a transfer with s_tlast and no byte ends it as it stands).
// Output channel m_*: eight transfers per message, digest words most significant
// first, word number in m_tdata[34:32], m_tlast on the eighth word.
// Flow: a byte is taken whenever s_tready is high. The byte that fills a 64-byte
// block starts a compression: 64 rounds on the single round unit plus the fold
// into the hash. An end transfer adds one pad byte per cycle, while no block is
// compressing, up to the block end, then one or two compressions and a handoff
// before the first digest word is valid. s_tready is high only while no block is
// compressing or padding and no digest is waiting to be handed off.
// The digest sits in its own buffer, so a stalled receiver does not hold the
// input: bytes of the next message are taken meanwhile; only the handoff of the
// next digest waits until the buffer has drained.
// Reset: synchronous, active low; loads the initial hash values, clears the
// byte counters and empties the digest buffer. No clearing pass is needed.
module sha256_stream_hasher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_number[34:32], zero fill
    output logic        m_tlast    // last_word
);
    import shs_pkg::*;

    state_t      state_reg, state_next;
    state_t      resume_reg, resume_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  len_idx_reg, len_idx_next;
    logic [5:0]  bytes_reg, bytes_next;
    logic [60:0] msg_bytes_reg, msg_bytes_next;
    logic [23:0] acc_reg, acc_next;

    logic        s_fire;
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic        out_load;
    logic        out_busy;
    logic [63:0] len_shifted;
    core_ctrl_t  core_ctrl;
    sched_cmd_t  sched_cmd;
    logic [31:0] w_t;
    hash_t       hash;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid && s_tready;

    // bit length, current byte of it at the top
    assign len_shifted = {msg_bytes_reg, 3'b000} << {len_idx_reg, 3'b000};

    // sequencer
    always_comb begin
        state_next     = state_reg;
        resume_next    = resume_reg;
        round_next     = round_reg;
        len_idx_next   = len_idx_reg;
        msg_bytes_next = msg_bytes_reg;
        wr_en          = 1'b0;
        wr_byte        = s_tdata;
        out_load       = 1'b0;
        core_ctrl      = '0;
        unique case (state_reg) inside
            ST_IDLE: begin
                if (s_fire) begin
                    wr_en = s_tuser;
                    if (s_tuser) begin
                        msg_bytes_next = msg_bytes_reg + 61'd1;
                    end
                    if (wr_en && bytes_reg == BLOCK_LAST_BYTE) begin
                        state_next  = ST_ROUND;
                        resume_next = s_tlast ? ST_MARK : ST_IDLE;
                    end else if (s_tlast) begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK, ST_ZERO: begin
                wr_en   = 1'b1;
                wr_byte = (state_reg == ST_MARK) ? PAD_MARK : 8'h00;
                if (bytes_reg == BLOCK_LAST_BYTE) begin
                    state_next  = ST_ROUND;
                    resume_next = ST_ZERO;
                end else if (bytes_reg == LEN_START_BYTE - 6'd1) begin
                    state_next = ST_LEN;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_LEN: begin
                wr_en        = 1'b1;
                wr_byte      = len_shifted[63:56];
                len_idx_next = len_idx_reg + 3'd1;
                if (len_idx_reg == LEN_LAST_BYTE) begin
                    state_next  = ST_ROUND;
                    resume_next = ST_HAND;
                end
            end
            ST_ROUND: begin
                core_ctrl.step = 1'b1;
                round_next     = round_reg + 6'd1;
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                core_ctrl.fold = 1'b1;
                state_next     = resume_reg;
            end
            ST_HAND: begin
                if (!out_busy) begin
                    out_load         = 1'b1;
                    core_ctrl.reinit = 1'b1;
                    msg_bytes_next   = '0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        core_ctrl.load = wr_en && (bytes_reg == BLOCK_LAST_BYTE);
    end

    // byte packing into words, big-endian
    always_comb begin
        bytes_next     = bytes_reg;
        acc_next       = acc_reg;
        sched_cmd.push = 1'b0;
        sched_cmd.step = (state_reg == ST_ROUND);
        sched_cmd.word = {acc_reg, wr_byte};
        if (wr_en) begin
            bytes_next     = bytes_reg + 6'd1;
            acc_next       = {acc_reg[15:0], wr_byte};
            sched_cmd.push = (bytes_reg[1:0] == WORD_LAST_LANE);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            resume_reg    <= ST_IDLE;
            round_reg     <= '0;
            len_idx_reg   <= '0;
            bytes_reg     <= '0;
            msg_bytes_reg <= '0;
        end else begin
            state_reg     <= state_next;
            resume_reg    <= resume_next;
            round_reg     <= round_next;
            len_idx_reg   <= len_idx_next;
            bytes_reg     <= bytes_next;
            msg_bytes_reg <= msg_bytes_next;
        end
    end

    // partial word, payload only
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    shs_sched u_sched (
        .aclk (aclk),
        .cmd  (sched_cmd),
        .w_t  (w_t)
    );

    shs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (core_ctrl),
        .round_idx (round_reg),
        .w_t       (w_t),
        .hash      (hash)
    );

    shs_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .digest   (hash),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // the last round always hands over to the fold
    a_round_to_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == ROUND_LAST) |=> (state_reg == ST_FOLD))
        else $error("round sequence did not end in fold");

    // length bytes only fill the last eight byte slots of a block
    a_len_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEN) |-> (bytes_reg[5:3] == 3'b111 && bytes_reg[2:0] == len_idx_reg))
        else $error("length byte out of place");

    // handoff happens on a block boundary
    a_hand_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HAND) |-> (bytes_reg == 6'd0 && round_reg == 6'd0))
        else $error("handoff with a partial block");

    // a block is compressed only from a full block
    a_load_full: assert property (@(posedge aclk) disable iff (!aresetn)
        core_ctrl.load |=> (state_reg == ST_ROUND && bytes_reg == 6'd0))
        else $error("compression started on a partial block");

endmodule
